>>> rtl/schas_pkg.sv
// Shared types and constants for the scan-code hold-and-accelerate setpoint core.
// Holds the key code table, the angle limits and the configuration and control structs.
// No dependencies.
package schas_pkg;

   localparam int NUM_KEYS      = 10;
   localparam int MAX_CHANNELS  = 5;
   localparam int ANGLE_W       = 8;
   localparam int COUNT_W       = 9;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;

   localparam logic [7:0] RELEASE_PREFIX = 8'hF0;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_SLOW_STEP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_FAST_STEP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_SLOW_STEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_FAST_STEP  = 3'd4;

   // Key order: up/down pairs for channels a..e
   localparam logic [7:0] KEY_CODES [NUM_KEYS] = '{
      8'h1C, 8'h1A, 8'h1B, 8'h22, 8'h23, 8'h21, 8'h2B, 8'h2A, 8'h34, 8'h32
   };

   typedef struct packed {
      logic [7:0] accel_threshold;
      logic [7:0] up_slow_step;
      logic [7:0] up_fast_step;
      logic [7:0] down_slow_step;
      logic [7:0] down_fast_step;
   } accel_cfg_type;

   typedef struct packed {
      logic advance;
      logic up_held;
      logic down_held;
   } chan_ctrl_type;

endpackage

>>> rtl/schas_key_decode.sv
// Scan byte decoder: release prefix tracking and the held-key bitmap.
// Depends on schas_pkg.
module schas_key_decode
   import schas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                byte_valid,
   input  logic [7:0]          scan_byte,
   output logic [NUM_KEYS-1:0] key_down_next
);

   logic                release_pending_ff;
   logic                release_pending_in;
   logic [NUM_KEYS-1:0] key_down_ff;

   // Apply this tick's byte to the flag and the bitmap
   always_comb begin
      release_pending_in = release_pending_ff;
      key_down_next      = key_down_ff;
      if (byte_valid) begin
         if (scan_byte == RELEASE_PREFIX) begin
            release_pending_in = 1'b1;
         end else begin
            release_pending_in = 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (scan_byte == KEY_CODES[k]) begin
                  key_down_next[k] = !release_pending_ff;
               end
            end
         end
      end
   end

   // Hold state until the word moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         release_pending_ff <= 1'b0;
         key_down_ff        <= '0;
      end else if (advance) begin
         release_pending_ff <= release_pending_in;
         key_down_ff        <= key_down_next;
      end
   end

endmodule

>>> rtl/schas_channel.sv
// One setpoint channel: up and down hold counters and the clamped angle.
// Depends on schas_pkg.
module schas_channel
   import schas_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  chan_ctrl_type       ctrl,
   input  accel_cfg_type       cfg,
   output logic [ANGLE_W-1:0]  angle_next
);

   logic [COUNT_W-1:0] up_count_ff, up_count_in;
   logic [COUNT_W-1:0] down_count_ff, down_count_in;
   logic [ANGLE_W-1:0] setpoint_ff;
   logic [COUNT_W-1:0] threshold;
   logic [COUNT_W-1:0] limit;
   logic [7:0]         up_step;
   logic [7:0]         down_step;
   logic [ANGLE_W:0]   up_sum;
   logic [ANGLE_W-1:0] after_up;

   assign threshold = {1'b0, cfg.accel_threshold};
   assign limit     = threshold + COUNT_W'(1);

   // Advance hold counters, saturating one past the threshold
   always_comb begin
      up_count_in = '0;
      if (ctrl.up_held) begin
         up_count_in = (up_count_ff >= limit) ? limit : up_count_ff + COUNT_W'(1);
      end
      down_count_in = '0;
      if (ctrl.down_held) begin
         down_count_in = (down_count_ff >= limit) ? limit : down_count_ff + COUNT_W'(1);
      end
   end

   assign up_step   = (up_count_in > threshold) ? cfg.up_fast_step : cfg.up_slow_step;
   assign down_step = (down_count_in > threshold) ? cfg.down_fast_step : cfg.down_slow_step;

   // Up step clamped at the top, then down step clamped at zero
   assign up_sum = {1'b0, setpoint_ff} + {1'b0, up_step};

   always_comb begin
      after_up = setpoint_ff;
      if (ctrl.up_held) begin
         after_up = (up_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : up_sum[ANGLE_W-1:0];
      end
      angle_next = after_up;
      if (ctrl.down_held) begin
         angle_next = (down_step > after_up) ? '0 : after_up - down_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_count_ff   <= '0;
         down_count_ff <= '0;
         setpoint_ff   <= ANGLE_RESET;
      end else if (ctrl.advance) begin
         up_count_ff   <= up_count_in;
         down_count_ff <= down_count_in;
         setpoint_ff   <= angle_next;
      end
   end

endmodule

>>> rtl/scancode_hold_accel_setpoints_core.sv
// Scan-code driven angle setpoints with hold acceleration.
// rsp_tvalid rises once the accepted word has passed the input register and then the result register;
// a blocked result register holds it in the input register. Throughput: one word per cycle while the result
// side drains; all channels update in parallel in the single compute stage. Reset (synchronous, active high):
// keys released, release flag clear, hold counts zero, every angle 90, registers at threshold 20,
// slow steps 1, fast steps 10; both stages empty. Depends on schas_pkg, schas_key_decode and schas_channel.
module scancode_hold_accel_setpoints_core
   import schas_pkg::*;
#(
   parameter int CHANNELS = MAX_CHANNELS
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] scan_byte
   input  logic                   req_tuser,  // [0] byte_valid
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [55:0]            rsp_tdata,  // [9:0] led_bits, [17:10] angle_a,
                                              // [25:18] angle_b, [33:26] angle_c,
                                              // [41:34] angle_d, [49:42] angle_e, zero pad
   // Configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   accel_cfg_type       cfg_ff;
   logic                in_valid_ff;
   logic                in_byte_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                rsp_valid_ff;
   logic [55:0]         rsp_data_ff;
   logic                stage_ready;
   logic                advance;
   logic [NUM_KEYS-1:0] key_down_next;
   logic [ANGLE_W-1:0]  angle_next [MAX_CHANNELS];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_threshold <= 8'd20;
         cfg_ff.up_slow_step    <= 8'd1;
         cfg_ff.up_fast_step    <= 8'd10;
         cfg_ff.down_slow_step  <= 8'd1;
         cfg_ff.down_fast_step  <= 8'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACCEL_THRESHOLD: cfg_ff.accel_threshold <= csr_wdata;
            CSR_UP_SLOW_STEP:    cfg_ff.up_slow_step    <= csr_wdata;
            CSR_UP_FAST_STEP:    cfg_ff.up_fast_step    <= csr_wdata;
            CSR_DOWN_SLOW_STEP:  cfg_ff.down_slow_step  <= csr_wdata;
            CSR_DOWN_FAST_STEP:  cfg_ff.down_fast_step  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: compute stage moves when the result register is free or draining
   assign stage_ready = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && stage_ready;
   assign req_tready  = !in_valid_ff || stage_ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_valid_ff <= req_tuser;
         in_byte_ff       <= req_tdata;
      end
   end

   // Key decoder
   schas_key_decode u_key_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .byte_valid    (in_byte_valid_ff),
      .scan_byte     (in_byte_ff),
      .key_down_next (key_down_next)
   );

   // Channels: active ones update, the rest hold their reset angle
   for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_chan
      if (i < CHANNELS) begin : g_active
         chan_ctrl_type ctrl;
         assign ctrl.advance   = advance;
         assign ctrl.up_held   = key_down_next[2*i];
         assign ctrl.down_held = key_down_next[2*i+1];
         schas_channel u_channel (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cfg        (cfg_ff),
            .angle_next (angle_next[i])
         );
      end else begin : g_idle
         assign angle_next[i] = ANGLE_RESET;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {6'd0, angle_next[4], angle_next[3], angle_next[2],
                         angle_next[1], angle_next[0], key_down_next};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("request stalled without a blocked result");

   a_angle_a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:10] <= ANGLE_MAX))
      else $error("angle_a beyond its limit");

   a_result_follows_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced word did not reach the result register");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

endmodule

>>> sim/setpoint_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the scan-code setpoint core: watches both streams and the register port.
// Predicts each result word from the accepted request words; depends on schas_pkg.
module setpoint_checker
   import schas_pkg::*;
#(
   parameter int CHANNELS = MAX_CHANNELS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [55:0]            rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     words_due
);

   localparam logic [7:0] RESET_THRESHOLD = 8'd20;
   localparam logic [7:0] RESET_SLOW_STEP = 8'd1;
   localparam logic [7:0] RESET_FAST_STEP = 8'd10;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0][ANGLE_W-1:0] angle;
      logic [NUM_KEYS-1:0]                  led_bits;
   } setpoint_word_type;

   // predictor copy of the registers
   logic [7:0] threshold;
   logic [7:0] up_slow;
   logic [7:0] up_fast;
   logic [7:0] down_slow;
   logic [7:0] down_fast;

   // predictor copy of the block state
   logic                                 release_armed;
   logic [NUM_KEYS-1:0]                  held_keys;
   logic [MAX_CHANNELS-1:0][COUNT_W-1:0] up_count;
   logic [MAX_CHANNELS-1:0][COUNT_W-1:0] down_count;
   logic [MAX_CHANNELS-1:0][ANGLE_W-1:0] angle;

   setpoint_word_type due_setpoints[$];

   // Advance the key map, hold counts and angles by one poll tick
   function automatic setpoint_word_type next_setpoints(input logic valid,
                                                        input logic [7:0] code);
      logic [COUNT_W-1:0] limit;
      logic [9:0]         sp;
      logic [7:0]         step;
      setpoint_word_type  w;
      limit = COUNT_W'(threshold) + COUNT_W'(1);
      if (valid) begin
         if (code == RELEASE_PREFIX) begin
            release_armed = 1'b1;
         end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (KEY_CODES[k] == code) held_keys[k] = !release_armed;
            end
            release_armed = 1'b0;
         end
      end
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sp = {2'b00, angle[ch]};
         // up first, clamped at the top
         if (held_keys[2*ch]) begin
            up_count[ch] = (up_count[ch] >= limit) ? limit : up_count[ch] + COUNT_W'(1);
            step = (up_count[ch] > COUNT_W'(threshold)) ? up_fast : up_slow;
            sp = sp + {2'b00, step};
            if (sp > {2'b00, ANGLE_MAX}) sp = {2'b00, ANGLE_MAX};
         end else begin
            up_count[ch] = '0;
         end
         // then down, clamped at zero
         if (held_keys[2*ch+1]) begin
            down_count[ch] = (down_count[ch] >= limit) ? limit
                                                       : down_count[ch] + COUNT_W'(1);
            step = (down_count[ch] > COUNT_W'(threshold)) ? down_fast : down_slow;
            sp = ({2'b00, step} > sp) ? 10'd0 : sp - {2'b00, step};
         end else begin
            down_count[ch] = '0;
         end
         angle[ch] = sp[ANGLE_W-1:0];
      end
      w.led_bits = held_keys;
      w.angle    = angle;
      return w;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      setpoint_word_type want;
      if (reset) begin
         threshold     = RESET_THRESHOLD;
         up_slow       = RESET_SLOW_STEP;
         up_fast       = RESET_FAST_STEP;
         down_slow     = RESET_SLOW_STEP;
         down_fast     = RESET_FAST_STEP;
         release_armed = 1'b0;
         held_keys     = '0;
         up_count      = '0;
         down_count    = '0;
         for (int ch = 0; ch < MAX_CHANNELS; ch++) angle[ch] = ANGLE_RESET;
         due_setpoints.delete();
         mismatches    = 0;
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_ACCEL_THRESHOLD: threshold = csr_wdata;
               CSR_UP_SLOW_STEP:    up_slow   = csr_wdata;
               CSR_UP_FAST_STEP:    up_fast   = csr_wdata;
               CSR_DOWN_SLOW_STEP:  down_slow = csr_wdata;
               CSR_DOWN_FAST_STEP:  down_fast = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            due_setpoints.push_back(next_setpoints(req_tuser, req_tdata));
         // compare the result word against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (due_setpoints.size() == 0) begin
               note_mismatch("unexpected result word, led_bits", 0, rsp_tdata[9:0]);
            end else begin
               want = due_setpoints.pop_front();
               if (rsp_tdata[9:0] !== want.led_bits)
                  note_mismatch("led_bits", want.led_bits, rsp_tdata[9:0]);
               for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
                  if (rsp_tdata[10+8*ch +: 8] !== want.angle[ch])
                     note_mismatch($sformatf("angle %0d", ch), want.angle[ch],
                                   rsp_tdata[10+8*ch +: 8]);
               end
            end
         end
      end
      words_due = due_setpoints.size();
   end

endmodule

>>> sim/scancode_hold_accel_setpoints_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for scancode_hold_accel_setpoints_core: drives scan-code ticks and registers.
// Depends on schas_pkg, the core and setpoint_checker, which predicts and compares.
module scancode_hold_accel_setpoints_core_tb;
   import schas_pkg::*;

   typedef enum int {
      KEY_A_UP, KEY_A_DOWN, KEY_B_UP, KEY_B_DOWN, KEY_C_UP,
      KEY_C_DOWN, KEY_D_UP, KEY_D_DOWN, KEY_E_UP, KEY_E_DOWN
   } key_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_UNUSED  = 3'd7;
   localparam int RSP_LONG_HOLD = 100;
   localparam int PHASE_WORDS   = 90;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [55:0]            rsp_tdata;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     mismatches;
   int                     words_due;
   bit                     send_idle_on = 1'b1;
   bit                     rsp_idle_on  = 1'b1;
   bit                     hold_asked   = 1'b0;

   always #1 clock = ~clock;

   scancode_hold_accel_setpoints_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   setpoint_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   // Offer one tick word after a random gap; return at the accepting edge
   task automatic send_tick(input logic valid, input logic [7:0] code);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= valid;
      req_tdata  <= code;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic press(input key_type key);
      send_tick(1'b1, KEY_CODES[key]);
   endtask

   task automatic lift(input key_type key);
      send_tick(1'b1, RELEASE_PREFIX);
      send_tick(1'b1, KEY_CODES[key]);
   endtask

   // Stop offering, let every predicted word drain, then cover the pipeline latency
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [7:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic apply_setting(input logic [7:0] th, input logic [7:0] us,
                                input logic [7:0] uf, input logic [7:0] ds,
                                input logic [7:0] df);
      wait_idle();
      write_reg(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST_UNUSED)),
                8'($urandom));
      write_reg(CSR_ACCEL_THRESHOLD, th);
      write_reg(CSR_UP_SLOW_STEP, us);
      write_reg(CSR_UP_FAST_STEP, uf);
      write_reg(CSR_DOWN_SLOW_STEP, ds);
      write_reg(CSR_DOWN_FAST_STEP, df);
   endtask

   // Mostly held keys with poll ticks in between, some noise and stray prefixes
   task automatic run_random(input int count, input bit burst);
      int r;
      logic [7:0] code;
      for (int i = 0; i < count; i++) begin
         if (i % 32 == 0) send_idle_on = ($urandom_range(0, 3) != 0);
         if (burst && i < 40) send_idle_on = 1'b0;
         r    = $urandom_range(0, 99);
         code = KEY_CODES[$urandom_range(0, NUM_KEYS - 1)];
         if (r < 40) begin
            send_tick(1'b0, 8'($urandom));
         end else if (r < 72) begin
            send_tick(1'b1, code);
         end else if (r < 90) begin
            send_tick(1'b1, RELEASE_PREFIX);
            send_tick(1'b1, code);
         end else if (r < 96) begin
            send_tick(1'b1, 8'($urandom));
         end else begin
            send_tick(1'b1, RELEASE_PREFIX);
         end
      end
   endtask

   // Result side: random stall per word, one long hold when asked
   initial begin : rsp_side
      int stall;
      int served;
      bit hold_taken;
      served     = 0;
      hold_taken = 1'b0;
      rsp_tready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (served % 32 == 0) rsp_idle_on = ($urandom_range(0, 3) != 0);
         stall = rsp_idle_on ? $urandom_range(0, 15) : 0;
         if (hold_asked && !hold_taken) begin
            stall      = RSP_LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         served++;
         @(negedge clock);
      end
   end

   initial begin : timeout
      #400000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed ticks at reset register values
      send_tick(1'b0, 8'hFF);
      send_tick(1'b1, 8'h00);
      press(KEY_A_UP);
      send_tick(1'b0, 8'h00);
      send_tick(1'b0, 8'h5A);
      press(KEY_A_DOWN);
      send_tick(1'b0, 8'hA5);
      // doubled prefix still releases just once
      send_tick(1'b1, RELEASE_PREFIX);
      lift(KEY_A_UP);
      // unmapped byte consumes an armed prefix
      send_tick(1'b1, RELEASE_PREFIX);
      send_tick(1'b1, 8'h00);
      press(KEY_B_UP);
      press(KEY_B_DOWN);
      press(KEY_C_UP);
      press(KEY_C_DOWN);
      press(KEY_D_UP);
      press(KEY_D_DOWN);
      press(KEY_E_UP);
      press(KEY_E_DOWN);
      send_tick(1'b1, RELEASE_PREFIX);
      send_tick(1'b1, 8'hFF);
      send_tick(1'b0, 8'hFF);

      // random phases over several register settings
      apply_setting(8'd20, 8'd1, 8'd10, 8'd1, 8'd10);
      run_random(PHASE_WORDS, 1'b0);
      apply_setting(8'd0, 8'd0, 8'd180, 8'd0, 8'd180);
      hold_asked = 1'b1;
      run_random(PHASE_WORDS, 1'b1);
      apply_setting(8'd255, 8'd180, 8'd0, 8'd180, 8'd0);
      run_random(PHASE_WORDS, 1'b0);
      apply_setting(8'($urandom_range(0, 8)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                    8'($urandom_range(0, 180)));
      run_random(PHASE_WORDS, 1'b0);
      apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 30)),
                    8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)),
                    8'($urandom_range(0, 30)));
      run_random(PHASE_WORDS, 1'b0);

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && words_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
